// ----- design/figure_eight_path_follower_assert.svh -----
// assertion macros for the checker file
`ifndef FIGURE_EIGHT_PATH_FOLLOWER_ASSERT_SVH
`define FIGURE_EIGHT_PATH_FOLLOWER_ASSERT_SVH

// implication on the same edge, quiet during reset
`define FEP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked on the next edge, quiet during reset
`define FEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication checked on the next edge, through reset as well
`define FEP_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/fep_pkg.sv -----
`timescale 1ns / 1ps

package fep_pkg;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 72;
  localparam int REG_W     = 23;
  localparam int CW        = 52;  // cordic datapath width
  localparam int QW        = 34;  // cos / sin in q2.30 with headroom
  localparam int PW        = 58;  // multiplier product width

  localparam logic [31:0] Q30_GAIN = 32'd652032874;

  // register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_CARROT = 2'd1;
  localparam logic [1:0] REG_SWITCH = 2'd2;

  // opcodes
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // arctangent of 2^-i in turn fractions (2^32 = one turn)
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- design/figure_eight_path_follower.sv -----
`timescale 1ns / 1ps
// figure-eight carrot generator
// input stream: s_tuser carries the opcode (init or step), s_tdata the pose.
// an init beat takes the pose as origin, builds four waypoints and two circle
// centres and returns waypoint one as the carrot. a step beat returns the
// carrot for the current segment and moves to the next segment once the
// pose is inside the switch distance of the segment's exit waypoint.
// output stream: one beat per input beat, carrot point and segment used.
// the beats share one cordic stage and one 24 x 34 multiplier, which run
// under a small sequencer; s_tready is high only while the sequencer idles.
// the cordic runs one micro-rotation per cycle.
// the result sits in an output register; when the receiver stalls the
// sequencer holds its finished result until the output register frees up.
// reset (synchronous, rst high) clears the geometry to zero, the segment to
// the first straight and the registers to 10 m, 3 m, 3 m. the user must write
// registers through the apb port while no beat is in flight (not enforced).
module figure_eight_path_follower #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_x [31:0], pos_y [63:32], heading [79:64]
  input  logic [fep_pkg::S_TDATA_W-1:0]   s_tdata,
  // opcode [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // carrot_x [31:0], carrot_y [63:32], segment [65:64], zero fill [71:66]
  output logic [fep_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import fep_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_VECL = 4'd1;
  localparam logic [3:0] ST_ROTL = 4'd2;
  localparam logic [3:0] ST_CORD = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_MULW = 4'd5;
  localparam logic [3:0] ST_FIN1 = 4'd6;
  localparam logic [3:0] ST_FIN2 = 4'd7;
  localparam logic [3:0] ST_CSUM = 4'd8;
  localparam logic [3:0] ST_NSET = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_CIRC = 2'd1;
  localparam logic [1:0] PH_NEAR = 2'd2;

  localparam logic signed [32:0] LIM_HI = 33'sd8388608;
  localparam logic signed [32:0] LIM_LO = -33'sd8388608;

  logic [3:0]          state;
  logic [REG_W-1:0]    path_radius, carrot_distance, switch_distance;
  logic [1:0]          current_segment, seg;
  logic [31:0]         px, py;
  logic [31:0]         wp [8];
  logic [31:0]         cc [4];
  logic [31:0]         cx, cy;
  logic [31:0]         ang;
  logic signed [CW-1:0] x, y;
  logic [31:0]         z;
  logic [1:0]          quad;
  logic                mode_rot;
  logic [IW-1:0]       i;
  logic [1:0]          phase, k;
  logic signed [QW-1:0] co, si;
  logic signed [PW-1:0] p;
  logic [31:0]         mres [4];
  logic [46:0]         acc;
  logic                near;
  logic [REG_W-1:0]    ax, ay;
  logic                out_valid;
  logic [M_TDATA_W-1:0] out_data;

  // apb register file
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_RADIUS: prdata = {9'b0, path_radius};
      REG_CARROT: prdata = {9'b0, carrot_distance};
      REG_SWITCH: prdata = {9'b0, switch_distance};
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_radius     <= REG_W'(655360);
      carrot_distance <= REG_W'(196608);
      switch_distance <= REG_W'(196608);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RADIUS: path_radius     <= pwdata[REG_W-1:0];
        REG_CARROT: carrot_distance <= pwdata[REG_W-1:0];
        REG_SWITCH: switch_distance <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // shared cordic micro-rotation
  logic signed [CW-1:0] xs, ys, x_nx, y_nx;
  logic [31:0]          at, z_nx;
  logic                 dir;
  always_comb begin
    xs  = x >>> i;
    ys  = y >>> i;
    at  = atan_turn(5'(i));
    dir = mode_rot ? !z[31] : !(!y[CW-1] && (y != '0));
    if (dir) begin
      x_nx = x - ys;
      y_nx = y + xs;
      z_nx = z - at;
    end else begin
      x_nx = x + ys;
      y_nx = y - xs;
      z_nx = z + at;
    end
  end

  // quadrant fold of the rotation result
  logic signed [QW-1:0] xq, yq, co_nx, si_nx;
  always_comb begin
    xq = x_nx[QW-1:0];
    yq = y_nx[QW-1:0];
    case (quad)
      2'd0:    begin co_nx = xq;  si_nx = yq;  end
      2'd1:    begin co_nx = -yq; si_nx = xq;  end
      2'd2:    begin co_nx = -xq; si_nx = -yq; end
      default: begin co_nx = yq;  si_nx = -xq; end
    endcase
  end

  // shared multiplier operand select and rounding
  logic [REG_W-1:0]     ma;
  logic signed [QW-1:0] mb;
  logic signed [PW-1:0] rnd, rsh;
  logic [31:0]          mq;
  always_comb begin
    ma = path_radius;
    mb = co;
    case (phase)
      PH_INIT: begin
        case (k)
          2'd0:    mb = co;
          2'd1:    mb = si;
          2'd2:    mb = -co;
          default: mb = -si;
        endcase
      end
      PH_CIRC: begin
        case (k)
          2'd0:    mb = co;
          2'd1:    mb = si;
          2'd2:    begin ma = carrot_distance; mb = seg[1] ? -si : si; end
          default: begin ma = carrot_distance; mb = seg[1] ? co : -co; end
        endcase
      end
      PH_NEAR: begin
        case (k)
          2'd0:    begin ma = ax; mb = QW'(ax); end
          2'd1:    begin ma = ay; mb = QW'(ay); end
          default: begin ma = switch_distance; mb = QW'(switch_distance); end
        endcase
      end
      default: ;
    endcase
    rnd = p + PW'(64'sd536870912);
    rsh = rnd >>> 30;
    mq  = rsh[31:0];
  end

  // point differences for the circle angle and the capture test
  logic [1:0]          cidx;
  logic [2:0]          widx;
  logic signed [32:0]  vdx, vdy, ndx, ndy, vdxa, vdyv, ndxa, ndya;
  always_comb begin
    cidx = {seg[1], 1'b0};
    widx = {seg, 1'b0};
    vdx  = $signed({px[31], px}) - $signed({cc[cidx[1:0]][31], cc[cidx[1:0]]});
    vdy  = $signed({py[31], py}) - $signed({cc[cidx[1:0] + 2'd1][31],
                                            cc[cidx[1:0] + 2'd1]});
    ndx  = $signed({px[31], px}) - $signed({wp[widx][31], wp[widx]});
    ndy  = $signed({py[31], py}) - $signed({wp[widx + 3'd1][31], wp[widx + 3'd1]});
    vdxa = vdx[32] ? -vdx : vdx;
    vdyv = vdx[32] ? -vdy : vdy;
    ndxa = ndx[32] ? -ndx : ndx;
    ndya = ndy[32] ? -ndy : ndy;
  end

  logic [31:0] rot_sum;
  assign rot_sum = ang + 32'h2000_0000;

  assign s_tready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      current_segment <= 2'd0;
      out_valid       <= 1'b0;
      for (int n = 0; n < 8; n++) wp[n] <= 32'b0;
      for (int n = 0; n < 4; n++) cc[n] <= 32'b0;
    end else begin
      if (out_valid && m_tready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            px   <= s_tdata[31:0];
            py   <= s_tdata[63:32];
            near <= 1'b0;
            if (s_tuser == OP_INIT) begin
              ang   <= {s_tdata[79:64], 16'b0};
              phase <= PH_INIT;
              seg   <= 2'd0;
              state <= ST_ROTL;
            end else begin
              seg <= current_segment;
              if (current_segment[0]) begin
                phase <= PH_CIRC;
                state <= ST_VECL;
              end else begin
                cx    <= wp[{current_segment, 1'b0}];
                cy    <= wp[{current_segment, 1'b1}];
                state <= ST_NSET;
              end
            end
          end
        end
        ST_VECL: begin
          if (vdx == '0 && vdy == '0) begin
            ang   <= 32'b0;
            state <= ST_ROTL;
          end else begin
            x        <= {{3{vdxa[32]}}, vdxa, 16'b0};
            y        <= {{3{vdyv[32]}}, vdyv, 16'b0};
            z        <= vdx[32] ? 32'h8000_0000 : 32'b0;
            mode_rot <= 1'b0;
            i        <= '0;
            state    <= ST_CORD;
          end
        end
        ST_ROTL: begin
          quad     <= rot_sum[31:30];
          z        <= ang - {rot_sum[31:30], 30'b0};
          x        <= CW'(Q30_GAIN);
          y        <= '0;
          mode_rot <= 1'b1;
          i        <= '0;
          state    <= ST_CORD;
        end
        ST_CORD: begin
          x <= x_nx;
          y <= y_nx;
          z <= z_nx;
          i <= i + 1'b1;
          if (i == LAST_STEP) begin
            if (mode_rot) begin
              co    <= co_nx;
              si    <= si_nx;
              k     <= 2'd0;
              state <= ST_MUL;
            end else begin
              ang   <= z_nx;
              state <= ST_ROTL;
            end
          end
        end
        ST_MUL: begin
          p     <= $signed({1'b0, ma}) * mb;
          state <= ST_MULW;
        end
        ST_MULW: begin
          k <= k + 2'd1;
          if (phase == PH_NEAR) begin
            case (k)
              2'd0: begin
                acc   <= p[46:0];
                state <= ST_MUL;
              end
              2'd1: begin
                acc   <= acc + p[46:0];
                state <= ST_MUL;
              end
              default: begin
                near  <= (acc < p[46:0]);
                state <= ST_DONE;
              end
            endcase
          end else begin
            mres[k] <= mq;
            if (k == 2'd3) state <= (phase == PH_INIT) ? ST_FIN1 : ST_CSUM;
            else state <= ST_MUL;
          end
        end
        ST_FIN1: begin
          wp[0] <= px + mres[0];
          wp[1] <= py + mres[1];
          wp[2] <= px + mres[1];
          wp[3] <= py + mres[2];
          wp[4] <= px + mres[3];
          wp[5] <= py + mres[0];
          wp[6] <= px + mres[2];
          wp[7] <= py + mres[3];
          state <= ST_FIN2;
        end
        ST_FIN2: begin
          cc[0]           <= wp[0] + mres[1];
          cc[1]           <= wp[1] + mres[2];
          cc[2]           <= wp[4] + mres[1];
          cc[3]           <= wp[5] + mres[2];
          cx              <= wp[0];
          cy              <= wp[1];
          current_segment <= 2'd0;
          state           <= ST_DONE;
        end
        ST_CSUM: begin
          cx    <= cc[cidx[1:0]] + mres[0] + mres[2];
          cy    <= cc[cidx[1:0] + 2'd1] + mres[1] + mres[3];
          state <= ST_NSET;
        end
        ST_NSET: begin
          if (ndx > LIM_LO && ndx < LIM_HI && ndy > LIM_LO && ndy < LIM_HI) begin
            ax    <= ndxa[REG_W-1:0];
            ay    <= ndya[REG_W-1:0];
            phase <= PH_NEAR;
            k     <= 2'd0;
            state <= ST_MUL;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {6'b0, seg, cy, cx};
            if (near) current_segment <= seg + 2'd1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- design/fep_checker.sv -----
`timescale 1ns / 1ps
`include "figure_eight_path_follower_assert.svh"

module fep_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fep_pkg::M_TDATA_W-1:0] m_tdata
);
  import fep_pkg::*;

  logic [M_TDATA_W-1:0] fill_check;
  assign fill_check = m_tdata;

  // reset leaves the output empty and the input open
  `FEP_ASSERT_RESET(a_reset_state, rst, !m_tvalid && s_tready)

  // an accepted beat keeps the sequencer busy on the next edge
  `FEP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // no result appears right after a beat is taken
  `FEP_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))

  // a stalled result holds, with zero fill above the segment
  `FEP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && fill_check[71:66] == 6'b0)

endmodule

bind figure_eight_path_follower fep_checker u_fep_checker (.*);
